>>> sv/escape_decode_tokenize_stream_macros.svh
// Assertion macros for the escape decode and tokenize stream block.
// Used by modules that hold concurrent checks; expects clk and arst_n in scope.
`ifndef ESCAPE_DECODE_TOKENIZE_STREAM_MACROS_SVH
`define ESCAPE_DECODE_TOKENIZE_STREAM_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define EDTS_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define EDTS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/edts_pkg.sv
// Shared types, constants and byte functions of the escape decode and tokenize block.
// Depends on nothing; used by the front, queue, back and top level.
`default_nettype none

package edts_pkg;

	localparam logic [7:0] BSLASH = 8'h5c;
	localparam logic [7:0] DQUOTE = 8'h22;
	localparam logic [7:0] NL     = 8'h0a;
	localparam logic [7:0] LBRACK = 8'h5b;
	localparam logic [7:0] RBRACK = 8'h5d;
	localparam logic [7:0] ZERO   = 8'h30;
	localparam logic [7:0] LOWX   = 8'h78;

	localparam int unsigned MASK_W   = 64;
	localparam int unsigned NUM_REGS = 4;
	localparam int unsigned IDX_W    = 2;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	localparam logic [2:0] POS_LAST = 3'd5;

	// One accepted input item after escape decoding and separator lookup.
	typedef struct packed {
		logic [7:0] d0;
		logic [7:0] d1;
		logic       sep0;
		logic       sep1;
		logic       has1;
		logic       eos;
	} job_t;

	// True when the byte is the second character of a known escape.
	function automatic logic esc_hit(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h6e, 8'h74, 8'h76, 8'h62, 8'h72, 8'h66, 8'h61, BSLASH, DQUOTE: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Decoded value of an escape; other bytes map to themselves.
	function automatic logic [7:0] esc_val(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			8'h6e:   r = 8'h0a;
			8'h74:   r = 8'h09;
			8'h76:   r = 8'h0b;
			8'h62:   r = 8'h08;
			8'h72:   r = 8'h0d;
			8'h66:   r = 8'h0c;
			8'h61:   r = 8'h07;
			default: r = c;
		endcase
		return r;
	endfunction

	// Bytes that print as bracketed hex.
	function automatic logic is_special(input logic [7:0] d);
		logic r;
		unique case (d)
			8'h0a, 8'h09, 8'h0b, 8'h08, 8'h0d, 8'h0c, 8'h07, BSLASH, DQUOTE: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'h0, v};
		end else begin
			r = 8'h57 + {4'h0, v};
		end
		return r;
	endfunction

	// Character at a position of the bracketed form [0xhh].
	function automatic logic [7:0] bracket_char(input logic [7:0] d, input logic [2:0] pos);
		logic [7:0] r;
		unique case (pos)
			3'd0:    r = LBRACK;
			3'd1:    r = ZERO;
			3'd2:    r = LOWX;
			3'd3:    r = hex_digit(d[7:4]);
			3'd4:    r = hex_digit(d[3:0]);
			default: r = RBRACK;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/edts_front.sv
// Front end: escape decoding, separator mask registers and separator lookup.
// Depends on edts_pkg; feeds decoded jobs into edts_queue.
`default_nettype none

module edts_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [edts_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [edts_pkg::MASK_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          end_of_stream,
	input  wire logic                          queue_full,
	output logic                               in_stall,
	output logic                               push,
	output edts_pkg::job_t                     job
);

	logic [edts_pkg::NUM_REGS-1:0][edts_pkg::MASK_W-1:0] mask_q;
	logic [edts_pkg::NUM_REGS*edts_pkg::MASK_W-1:0]      mask_flat;
	logic                                                pending_q;
	logic                                                accept;
	logic                                                makes_job;

	assign mask_flat = mask_q;
	assign in_stall  = queue_full;
	assign accept    = in_valid && !queue_full;
	// A lone backslash that is not the last byte only opens an escape.
	assign makes_job = pending_q || !((in_byte == edts_pkg::BSLASH) && !end_of_stream);
	assign push      = accept && makes_job;

	always_comb begin
		job.eos = end_of_stream;
		job.d1  = in_byte;
		if (pending_q && !edts_pkg::esc_hit(in_byte)) begin
			job.d0   = edts_pkg::BSLASH;
			job.has1 = 1'b1;
		end else if (pending_q) begin
			job.d0   = edts_pkg::esc_val(in_byte);
			job.has1 = 1'b0;
		end else begin
			job.d0   = in_byte;
			job.has1 = 1'b0;
		end
		job.sep0 = mask_flat[job.d0];
		job.sep1 = mask_flat[job.d1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			mask_q    <= '0;
		end else begin
			if (cfg_we) begin
				mask_q[cfg_index] <= cfg_data;
			end
			if (accept) begin
				pending_q <= !pending_q && (in_byte == edts_pkg::BSLASH) && !end_of_stream;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/edts_queue.sv
// Short job queue between the front end and the print sequencer.
// Depends on edts_pkg for the job type and depth.
`default_nettype none

module edts_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire edts_pkg::job_t  din,
	input  wire logic            pop,
	output edts_pkg::job_t       dout,
	output logic                 valid,
	output logic                 full
);

	edts_pkg::job_t                  entry_q [edts_pkg::QDEPTH];
	logic [edts_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [edts_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [edts_pkg::QCNT_W-1:0]     count_q;

	assign dout  = entry_q[rd_ptr_q];
	assign valid = (count_q != '0);
	assign full  = (count_q == edts_pkg::QCNT_W'(edts_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/edts_back.sv
// Back end: prints decoded jobs one output byte per cycle while the output is not stalled, into an output register.
// Depends on edts_pkg and the assertion macros header.
`default_nettype none
`include "escape_decode_tokenize_stream_macros.svh"

module edts_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_valid,
	input  wire edts_pkg::job_t  job_in,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           out_byte,
	output logic                 last_of_run
);

	typedef enum logic {PH_BYTE, PH_EOS} phase_t;

	phase_t          phase_q;
	edts_pkg::job_t  job_q;
	logic            busy_q;
	logic            sel_q;
	logic [2:0]      pos_q;
	logic            lb_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	logic            advance;
	logic            step;
	logic [7:0]      cur_d;
	logic            cur_sep;
	logic            brk;
	logic            byte_done;
	logic            more_byte;
	logic            job_done;
	logic [7:0]      emit_byte;
	logic            mid_bracket;
	logic            on_special;

	assign advance   = !out_valid_q || !out_stall;
	assign step      = busy_q && advance;
	assign cur_d     = sel_q ? job_q.d1 : job_q.d0;
	assign cur_sep   = sel_q ? job_q.sep1 : job_q.sep0;
	// A separator breaks the line only at the start of a byte and only once in a row.
	assign brk       = (pos_q == 3'd0) && cur_sep && !lb_q;
	assign more_byte = !sel_q && job_q.has1;

	assign mid_bracket = busy_q && (pos_q != 3'd0);
	assign on_special  = (phase_q == PH_BYTE) && edts_pkg::is_special(cur_d);

	always_comb begin
		byte_done = 1'b0;
		job_done  = 1'b0;
		emit_byte = edts_pkg::NL;
		unique case (phase_q)
			PH_EOS: begin
				job_done = 1'b1;
			end
			PH_BYTE: begin
				if (brk) begin
					byte_done = 1'b1;
				end else if (edts_pkg::is_special(cur_d)) begin
					emit_byte = edts_pkg::bracket_char(cur_d, pos_q);
					byte_done = (pos_q == edts_pkg::POS_LAST);
				end else begin
					emit_byte = cur_d;
					byte_done = 1'b1;
				end
				job_done = byte_done && !more_byte && !job_q.eos;
			end
			default: begin
				job_done = 1'b1;
			end
		endcase
	end

	assign pop = job_valid && (!busy_q || (step && job_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BYTE;
			busy_q      <= 1'b0;
			sel_q       <= 1'b0;
			pos_q       <= 3'd0;
			lb_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				if (phase_q == PH_EOS) begin
					lb_q <= 1'b0;
				end else if (brk) begin
					lb_q <= 1'b1;
				end else if (pos_q == 3'd0) begin
					lb_q <= 1'b0;
				end
			end
			if (pop) begin
				busy_q  <= 1'b1;
				sel_q   <= 1'b0;
				pos_q   <= 3'd0;
				phase_q <= PH_BYTE;
			end else if (step) begin
				if (phase_q != PH_EOS) begin
					if (byte_done) begin
						pos_q <= 3'd0;
						if (more_byte) begin
							sel_q <= 1'b1;
						end else if (job_q.eos) begin
							phase_q <= PH_EOS;
						end
					end else begin
						pos_q <= pos_q + 3'd1;
					end
				end
				if (job_done) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_in;
		end
		if (step) begin
			out_byte_q <= emit_byte;
			out_last_q <= job_done;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

	`EDTS_CHECK(a_pos_range, pos_q <= edts_pkg::POS_LAST, "bracket position out of range")
	`EDTS_IMPLY(a_pos_special, mid_bracket, on_special, "bracket position set on a plain byte")
	`EDTS_IMPLY(a_eos_phase, busy_q && (phase_q == PH_EOS), job_q.eos, "stray closing newline")
	`EDTS_IMPLY(a_pop_busy, pop && busy_q, step && job_done, "job loaded over an unfinished job")

endmodule

`default_nettype wire

>>> sv/escape_decode_tokenize_stream.sv
// Escape decode and tokenize: one output byte per cycle while the output is not stalled; an item gives 0 to 13 bytes.
// The first output byte of an item passes through the queue, the job register and the output register.
// The print sequencer sets the pace; a special byte prints in the bracketed hex form [0xhh].
// Asynchronous active-low reset clears escape and line state, the queue and the masks.
// Depends on edts_pkg, edts_front, edts_queue and edts_back.
`default_nettype none

module escape_decode_tokenize_stream (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [edts_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [edts_pkg::MASK_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          end_of_stream,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [7:0]                         out_byte,
	output logic                               last_of_run
);

	// The front end decodes each beat into at most two bytes, looks both up in
	// the separator mask and pushes one job into the queue. A beat that only
	// opens an escape pushes nothing. The front stalls only when the queue is full.
	edts_pkg::job_t  front_job;
	edts_pkg::job_t  head_job;
	logic            push;
	logic            pop;
	logic            head_valid;
	logic            queue_full;

	edts_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.queue_full    (queue_full),
		.in_stall      (in_stall),
		.push          (push),
		.job           (front_job)
	);

	// The queue lets the front keep taking beats while the back end works
	// through a long bracketed run or waits on a stalled output.
	edts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_job),
		.pop    (pop),
		.dout   (head_job),
		.valid  (head_valid),
		.full   (queue_full)
	);

	// The back end keeps the line-broken state and sequences the printed bytes.
	// It loads the next job in the cycle it finishes one, so runs follow back to back.
	edts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (head_valid),
		.job_in      (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire
